### sv/lprt_pkg.sv
// Shared types, codes and helpers for the longest-prefix route table.
package lprt_pkg;

    localparam int unsigned ENTRIES_DEF = 16;
    localparam int unsigned IFACES_DEF  = 16;

    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
    localparam logic [5:0]  PLEN_MAX = 6'd32;

    typedef enum logic [2:0] {
        CMD_ADD_IF  = 3'd0,
        CMD_ADD_GW  = 3'd1,
        CMD_FWD     = 3'd2,
        CMD_SELF    = 3'd3,
        CMD_SRC     = 3'd4
    } lprt_cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } lprt_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } lprt_state_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] addr;
        logic [5:0]  prefix_len;
        logic [31:0] gateway_addr;
        logic [3:0]  iface;
    } lprt_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  out_iface;
        logic [31:0] next_hop;
        logic [31:0] src_addr;
        logic        is_broadcast;
    } lprt_rsp_t;

    // One stored record, one memory word.
    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] network;
        logic [31:0] bcast;
        logic [5:0]  plen;
        logic [31:0] gateway;
        logic [31:0] gw_src;
        logic [3:0]  iface;
    } lprt_rec_t;

    function automatic logic [31:0] mask_of(input logic [5:0] plen);
        logic [31:0] m;
        if (plen == 6'd0)
            m = 32'd0;
        else if (plen >= PLEN_MAX)
            m = ALL_ONES;
        else
            m = ~(ALL_ONES >> plen);
        return m;
    endfunction

endpackage

### sv/lprt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lprt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/longest_prefix_route_table_core.sv
// Top level of the IPv4 longest-prefix route table.
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one command item:
//   add interface, add gateway route, forward, self or source lookup.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one result
//   item per command, in command order.
//   Records live in one RAM with a registered read. Every scan walks the
//   n stored records from newest to oldest, one read per cycle, as the
//   RAM has a single read port. An add writes its record in the finish
//   state, so the next command always sees it.
//   req_stall is low only while the core is idle. A finished result waits
//   in the output register; the core takes the next item meanwhile and
//   holds its own result in the finish state until rsp_stall lets the
//   register drain.
//   Reset (rst_n low, asynchronous) empties the table by clearing the
//   record count; the RAM itself is not cleared, as unwritten words are
//   never read.
module longest_prefix_route_table_core
    import lprt_pkg::*;
#(
    parameter int unsigned ENTRIES = ENTRIES_DEF,
    parameter int unsigned IFACES  = IFACES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  lprt_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output lprt_rsp_t rsp
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

    // FSM and counters
    lprt_state_t      state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;   // records stored
    logic [CNT_W-1:0] left_reg,  left_next;    // reads still to issue
    logic             rd_valid_reg, rd_valid_next;
    logic [CNT_W-1:0] left_dec;

    // latched command
    lprt_req_t   cmd_reg, cmd_next;
    logic [31:0] key;
    logic        table_full;
    logic        iface_ok;
    logic        need_scan;

    // best matches: all records (b0), interface records (b1), self hit
    logic        b0_valid_reg, b0_valid_next;
    lprt_rec_t   b0_rec_reg,   b0_rec_next;
    logic        b1_valid_reg, b1_valid_next;
    logic [5:0]  b1_plen_reg,  b1_plen_next;
    logic [31:0] b1_addr_reg,  b1_addr_next;
    logic        found_reg,    found_next;
    logic [3:0]  sf_iface_reg, sf_iface_next;
    logic [31:0] sf_addr_reg,  sf_addr_next;
    logic        sf_bc_reg,    sf_bc_next;

    // output register
    logic        rsp_valid_reg, rsp_valid_next;
    lprt_rsp_t   rsp_reg,       rsp_next;

    // FSM outputs
    logic        req_acc;
    logic        scan_issue;
    logic        fin_go;

    // RAM
    logic                        mem_we;
    logic [IDX_W-1:0]            mem_waddr;
    logic [IDX_W-1:0]            mem_raddr;
    logic [$bits(lprt_rec_t)-1:0] mem_rdata_raw;
    lprt_rec_t                   mem_rdata;
    lprt_rec_t                   new_rec;
    logic [5:0]                  new_plen;
    logic [31:0]                 new_mask;

    // scan compare on the word just read
    logic [31:0] rd_mask;
    logic        rd_match;
    logic        rd_is_if;
    logic        rd_if_sel;

    lprt_ram #(
        .WIDTH ($bits(lprt_rec_t)),
        .DEPTH (ENTRIES)
    ) u_rec_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (new_rec),
        .raddr (mem_raddr),
        .rdata (mem_rdata_raw)
    );

    assign mem_rdata = lprt_rec_t'(mem_rdata_raw);

    // ---------------- command decode ----------------
    assign key        = (cmd_reg.cmd == CMD_ADD_GW) ? cmd_reg.gateway_addr : cmd_reg.addr;
    assign table_full = (count_reg >= CNT_W'(ENTRIES));
    assign iface_ok   = ({5'd0, cmd_reg.iface} < 9'(IFACES));

    // decode of the incoming item, used at acceptance
    always_comb
    begin
        need_scan = 1'b0;
        case (req.cmd)
            CMD_ADD_GW: need_scan = (count_reg < CNT_W'(ENTRIES));
            CMD_FWD:    need_scan = 1'b1;
            CMD_SELF:   need_scan = 1'b1;
            CMD_SRC:    need_scan = ({5'd0, req.iface} < 9'(IFACES));
            default:    need_scan = 1'b0;
        endcase
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (left_reg == '0)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- FSM outputs ----------------
    always_comb
    begin
        req_stall  = 1'b1;
        scan_issue = 1'b0;
        fin_go     = 1'b0;
        case (state_reg)
            ST_IDLE:   req_stall  = 1'b0;
            ST_SCAN:   scan_issue = (left_reg != '0);
            ST_FINISH: fin_go     = !rsp_valid_reg || !rsp_stall;
            default:   req_stall  = 1'b1;
        endcase
    end

    assign req_acc   = req_valid && !req_stall;
    assign left_dec  = left_reg - CNT_W'(1);
    assign mem_raddr = left_dec[IDX_W-1:0];
    assign mem_waddr = count_reg[IDX_W-1:0];

    // ---------------- scan compare ----------------
    assign rd_mask   = mask_of(mem_rdata.plen);
    assign rd_match  = ((key & rd_mask) == mem_rdata.network);
    assign rd_is_if  = (mem_rdata.gateway[31:24] == 8'd0);
    // source lookup narrows the interface-record match to one interface
    assign rd_if_sel = rd_is_if &&
                       ((cmd_reg.cmd != CMD_SRC) || (mem_rdata.iface == cmd_reg.iface));

    // ---------------- new record for adds ----------------
    assign new_plen = (cmd_reg.prefix_len > PLEN_MAX) ? PLEN_MAX : cmd_reg.prefix_len;
    assign new_mask = mask_of(new_plen);

    always_comb
    begin
        new_rec.addr    = cmd_reg.addr;
        new_rec.network = cmd_reg.addr & new_mask;
        new_rec.bcast   = cmd_reg.addr | ~new_mask;
        new_rec.plen    = new_plen;
        if (cmd_reg.cmd == CMD_ADD_GW)
        begin
            new_rec.gateway = cmd_reg.gateway_addr;
            new_rec.gw_src  = b1_valid_reg ? b1_addr_reg : 32'd0;
            new_rec.iface   = b0_rec_reg.iface;
        end
        else
        begin
            new_rec.gateway = 32'd0;
            new_rec.gw_src  = 32'd0;
            new_rec.iface   = cmd_reg.iface;
        end
    end

    // ---------------- datapath next values ----------------
    always_comb
    begin
        cmd_next       = cmd_reg;
        left_next      = left_reg;
        rd_valid_next  = 1'b0;
        b0_valid_next  = b0_valid_reg;
        b0_rec_next    = b0_rec_reg;
        b1_valid_next  = b1_valid_reg;
        b1_plen_next   = b1_plen_reg;
        b1_addr_next   = b1_addr_reg;
        found_next     = found_reg;
        sf_iface_next  = sf_iface_reg;
        sf_addr_next   = sf_addr_reg;
        sf_bc_next     = sf_bc_reg;
        count_next     = count_reg;
        mem_we         = 1'b0;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        if (req_acc)
        begin
            cmd_next      = req;
            left_next     = need_scan ? count_reg : '0;
            b0_valid_next = 1'b0;
            b1_valid_next = 1'b0;
            found_next    = 1'b0;
        end

        if (scan_issue)
        begin
            left_next     = left_dec;
            rd_valid_next = 1'b1;
        end

        // newest first: strict > keeps the newer record on equal length
        if (rd_valid_reg)
        begin
            if (rd_match && (!b0_valid_reg || (mem_rdata.plen > b0_rec_reg.plen)))
            begin
                b0_valid_next = 1'b1;
                b0_rec_next   = mem_rdata;
            end
            if (rd_match && rd_if_sel && (!b1_valid_reg || (mem_rdata.plen > b1_plen_reg)))
            begin
                b1_valid_next = 1'b1;
                b1_plen_next  = mem_rdata.plen;
                b1_addr_next  = mem_rdata.addr;
            end
            if (!found_reg && rd_is_if &&
                ((mem_rdata.addr == key) || (mem_rdata.bcast == key)))
            begin
                found_next    = 1'b1;
                sf_iface_next = mem_rdata.iface;
                sf_addr_next  = mem_rdata.addr;
                sf_bc_next    = (mem_rdata.addr != key);
            end
        end

        if (fin_go)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '{status: STAT_NOT_FOUND, out_iface: 4'd0, next_hop: 32'd0,
                               src_addr: 32'd0, is_broadcast: 1'b0};
            case (cmd_reg.cmd)
                CMD_ADD_IF:
                begin
                    if (table_full)
                        rsp_next.status = STAT_FULL;
                    else if (iface_ok)
                    begin
                        mem_we             = 1'b1;
                        count_next         = count_reg + CNT_W'(1);
                        rsp_next.status    = STAT_OK;
                        rsp_next.out_iface = cmd_reg.iface;
                        rsp_next.src_addr  = cmd_reg.addr;
                    end
                end
                CMD_ADD_GW:
                begin
                    if (table_full)
                        rsp_next.status = STAT_FULL;
                    else if (b0_valid_reg)
                    begin
                        mem_we             = 1'b1;
                        count_next         = count_reg + CNT_W'(1);
                        rsp_next.status    = STAT_OK;
                        rsp_next.out_iface = new_rec.iface;
                        rsp_next.src_addr  = new_rec.gw_src;
                    end
                end
                CMD_FWD:
                begin
                    if (b0_valid_reg)
                    begin
                        rsp_next.status    = STAT_OK;
                        rsp_next.out_iface = b0_rec_reg.iface;
                        if (b0_rec_reg.gateway[31:24] == 8'd0)
                        begin
                            rsp_next.next_hop = cmd_reg.addr;
                            rsp_next.src_addr = b0_rec_reg.addr;
                        end
                        else
                        begin
                            rsp_next.next_hop = b0_rec_reg.gateway;
                            rsp_next.src_addr = b0_rec_reg.gw_src;
                        end
                    end
                end
                CMD_SELF:
                begin
                    if (found_reg)
                    begin
                        rsp_next.status       = STAT_OK;
                        rsp_next.out_iface    = sf_iface_reg;
                        rsp_next.src_addr     = sf_addr_reg;
                        rsp_next.is_broadcast = sf_bc_reg;
                    end
                end
                CMD_SRC:
                begin
                    if (iface_ok && b1_valid_reg)
                    begin
                        rsp_next.status    = STAT_OK;
                        rsp_next.out_iface = cmd_reg.iface;
                        rsp_next.src_addr  = b1_addr_reg;
                    end
                end
                default: rsp_next.status = STAT_NOT_FOUND;
            endcase
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            b0_valid_reg  <= 1'b0;
            b1_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            rd_valid_reg  <= rd_valid_next;
            b0_valid_reg  <= b0_valid_next;
            b1_valid_reg  <= b1_valid_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        b0_rec_reg   <= b0_rec_next;
        b1_plen_reg  <= b1_plen_next;
        b1_addr_reg  <= b1_addr_next;
        sf_iface_reg <= sf_iface_next;
        sf_addr_reg  <= sf_addr_next;
        sf_bc_reg    <= sf_bc_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // the record count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("record count above table size");

    // read data only arrives while scanning
    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == ST_SCAN))
        else $error("read data outside scan");

    // each RAM write adds exactly one record
    a_write_counts: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("write without count step");

    // a new result only comes out of the finish state
    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !$past(rsp_valid_reg && rsp_stall)) |->
            ($past(state_reg) == ST_FINISH))
        else $error("result not from finish state");
`endif

endmodule
